[design/hufd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hufd_pkg
// Shared types and constants of the static Huffman tree decoder.
// ----------------------------------------------------------------------------
package hufd_pkg;

	// Default leaf table size.
	localparam int unsigned MAX_SYMBOLS_DEF = 256;

	// Fixed field widths.
	localparam int unsigned CMD_W    = 2;
	localparam int unsigned SYM_W    = 8;
	localparam int unsigned EWEIGHT_W = 24;
	localparam int unsigned WEIGHT_W = 32;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned TOTAL_W  = 32;

	// Input commands.
	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_BUILD = 2'd2,
		CMD_DATA  = 2'd3
	} cmd_t;

	// Result kinds.
	localparam logic KIND_SYMBOL = 1'b0;
	localparam logic KIND_ACK    = 1'b1;

	// Control from the sequencer to the root scan unit.
	typedef struct packed {
		logic clear;   // start a new scan
		logic valid;   // a free root is presented
	} scan_ctl_t;

endpackage
`default_nettype wire

[design/hufd_req_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hufd_req_if
// Command channel: clear, leaf load, tree build and data byte items.
// ----------------------------------------------------------------------------
interface hufd_req_if;
	logic                              valid;
	logic                              ready;
	logic [hufd_pkg::CMD_W-1:0]        cmd;
	logic [hufd_pkg::SYM_W-1:0]        entry_symbol;
	logic [hufd_pkg::EWEIGHT_W-1:0]    entry_weight;
	logic [hufd_pkg::BYTE_W-1:0]       data_byte;

	modport source (output valid, cmd, entry_symbol, entry_weight, data_byte, input ready);
	modport sink (input valid, cmd, entry_symbol, entry_weight, data_byte, output ready);
endinterface
`default_nettype wire

[design/hufd_rsp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hufd_rsp_if
// Result channel: decoded symbols and build acknowledgements.
// ----------------------------------------------------------------------------
interface hufd_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic [hufd_pkg::SYM_W-1:0]   symbol;
	logic                         last_of_item;
	logic                         stream_done;

	modport source (output valid, kind, symbol, last_of_item, stream_done, input ready);
	modport sink (input valid, kind, symbol, last_of_item, stream_done, output ready);
endinterface
`default_nettype wire

[design/hufd_cfg_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hufd_cfg_if
// Configuration write channel for the symbol total register.
// ----------------------------------------------------------------------------
interface hufd_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [hufd_pkg::TOTAL_W-1:0]   data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

[design/hufd_scan.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hufd_scan
// Picks the two roots to join from a stream of free roots in index order.
// ----------------------------------------------------------------------------
module hufd_scan #(
	parameter int unsigned NW = 9
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire hufd_pkg::scan_ctl_t               ctl,
	input  wire logic [NW-1:0]                     idx,
	input  wire logic [hufd_pkg::WEIGHT_W-1:0]     weight,
	output logic      [NW-1:0]                     a,
	output logic      [hufd_pkg::WEIGHT_W-1:0]     wa,
	output logic      [NW-1:0]                     b,
	output logic      [hufd_pkg::WEIGHT_W-1:0]     wb
);

	logic                            any_q;
	logic                            c_ok_q;
	logic [NW-1:0]                   a_q, c_q, m_q;
	logic [hufd_pkg::WEIGHT_W-1:0]   wa_q, wc_q, wm_q;

	// Track the first least root, the first least of the others and the last greatest.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q  <= 1'b0;
			c_ok_q <= 1'b0;
		end else if (ctl.clear) begin
			any_q  <= 1'b0;
			c_ok_q <= 1'b0;
		end else if (ctl.valid) begin
			if (!any_q) begin
				any_q <= 1'b1;
				a_q   <= idx;
				wa_q  <= weight;
				m_q   <= idx;
				wm_q  <= weight;
			end else begin
				if (weight < wa_q) begin
					c_q    <= a_q;
					wc_q   <= wa_q;
					c_ok_q <= 1'b1;
					a_q    <= idx;
					wa_q   <= weight;
				end else if (!c_ok_q || weight < wc_q) begin
					c_q    <= idx;
					wc_q   <= weight;
					c_ok_q <= 1'b1;
				end
				if (weight >= wm_q) begin
					m_q  <= idx;
					wm_q <= weight;
				end
			end
		end
	end

	// The second choice falls back to the last greatest root.
	always_comb begin
		a  = a_q;
		wa = wa_q;
		if (c_ok_q && wc_q < wm_q) begin
			b  = c_q;
			wb = wc_q;
		end else begin
			b  = m_q;
			wb = wm_q;
		end
	end

endmodule
`default_nettype wire

[design/huffman_tree_decoder_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// huffman_tree_decoder_unit
// Static Huffman decoder: loads leaves, builds the tree in node memories and
// walks data bytes bit by bit from the root.
// ----------------------------------------------------------------------------
//  Channel  Dir  Carries                                      Transfer
//  req      in   cmd, entry_symbol, entry_weight, data_byte   valid & ready
//  rsp      out  kind, symbol, last_of_item, stream_done      valid & ready
//  cfg      in   data (symbol total)                          valid & ready
//
//  Clear and load complete when accepted. A build with n >= 1 leaves first
//  clears the joined flags of the leaves, then for every new node i scans
//  weight memory nodes 0 .. i-1 and writes the node and its joined flags.
//  A data byte is walked from the root one code bit at a time; each decoded
//  symbol is handed out, the last one closing the item (registered reads).
//  Reset is asynchronous and clears all control state; memories hold no reset.
//  A stalled rsp holds the walk; req is taken only between items.
// ----------------------------------------------------------------------------
module huffman_tree_decoder_unit #(
	parameter int unsigned MAX_SYMBOLS = hufd_pkg::MAX_SYMBOLS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	hufd_req_if.sink   req,
	hufd_rsp_if.source rsp,
	hufd_cfg_if.sink   cfg
);

	localparam int unsigned NODES = 2 * MAX_SYMBOLS - 1;
	localparam int unsigned NW    = $clog2(NODES);
	localparam int unsigned CW    = $clog2(MAX_SYMBOLS + 1);
	localparam int unsigned SA    = $clog2(MAX_SYMBOLS);
	localparam int unsigned WW    = hufd_pkg::WEIGHT_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLR_RD, ST_CLR_WR, ST_SCAN, ST_NODE, ST_JOIN_A, ST_JOIN_B,
		ST_ACK, ST_STEP, ST_WAIT_N, ST_WAIT_L, ST_SYM, ST_FLUSH
	} state_t;

	state_t state_q;

	// Control and walk registers.
	logic [CW-1:0]                  leaf_count_q;
	logic [NW-1:0]                  walk_q, root_q, leaf_q, i_q, j_q;
	logic [hufd_pkg::TOTAL_W-1:0]   emitted_q, total_q;
	logic                           tree_valid_q;
	logic                           vld_s1;
	logic [NW-1:0]                  idx_s1;
	logic [hufd_pkg::BYTE_W-1:0]    byte_q;
	logic [3:0]                     bit_q;
	logic                           held_q, held_done_q;
	logic [hufd_pkg::SYM_W-1:0]     held_sym_q;

	// Output register.
	logic                           o_valid_q, o_kind_q, o_last_q, o_done_q;
	logic [hufd_pkg::SYM_W-1:0]     o_sym_q;

	// Memories: weight with joined flag, children, leaf symbols.
	logic [WW:0]                    wmem [NODES];
	logic [2*NW-1:0]                cmem [NODES];
	logic [hufd_pkg::SYM_W-1:0]     smem [MAX_SYMBOLS];
	logic [WW:0]                    w_rd_q;
	logic [2*NW-1:0]                c_rd_q;
	logic [hufd_pkg::SYM_W-1:0]     s_rd_q;

	logic                           w_we;
	logic [NW-1:0]                  w_wa;
	logic [WW:0]                    w_wd;

	// Scan unit connections.
	hufd_pkg::scan_ctl_t            scan_ctl;
	logic [NW-1:0]                  sc_a, sc_b;
	logic [WW-1:0]                  sc_wa, sc_wb;

	// Derived values.
	logic                           accept;
	logic                           out_free;
	logic [NW:0]                    two_n;
	logic [NW-1:0]                  leaf_count_n;
	logic [NW-1:0]                  next_node;
	logic                           load_ok;
	hufd_pkg::cmd_t                 cmd;

	assign accept       = req.valid && req.ready;
	assign out_free     = !o_valid_q || rsp.ready;
	assign two_n        = (NW+1)'({leaf_count_q, 1'b0});
	assign leaf_count_n = NW'(leaf_count_q);
	assign next_node    = byte_q[hufd_pkg::BYTE_W-1] ? c_rd_q[2*NW-1:NW] : c_rd_q[NW-1:0];
	assign load_ok      = leaf_count_q < CW'(MAX_SYMBOLS);
	assign cmd          = hufd_pkg::cmd_t'(req.cmd);

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	assign rsp.valid        = o_valid_q;
	assign rsp.kind         = o_kind_q;
	assign rsp.symbol       = o_sym_q;
	assign rsp.last_of_item = o_last_q;
	assign rsp.stream_done  = o_done_q;

	// Weight memory write port selection.
	always_comb begin
		w_we = 1'b0;
		w_wa = i_q;
		w_wd = {1'b0, sc_wa + sc_wb};
		unique case (state_q)
			ST_IDLE: begin
				w_we = accept && cmd == hufd_pkg::CMD_LOAD && load_ok;
				w_wa = leaf_count_n;
				w_wd = {1'b0, WW'(req.entry_weight)};
			end
			ST_CLR_WR: begin
				w_we = 1'b1;
				w_wa = j_q;
				w_wd = {1'b0, w_rd_q[WW-1:0]};
			end
			ST_NODE: begin
				w_we = 1'b1;
			end
			ST_JOIN_A: begin
				w_we = 1'b1;
				w_wa = sc_a;
				w_wd = {1'b1, sc_wa};
			end
			ST_JOIN_B: begin
				w_we = 1'b1;
				w_wa = sc_b;
				w_wd = {1'b1, sc_wb};
			end
			default: begin
				w_we = 1'b0;
			end
		endcase
	end

	// Weight memory: read address is the scan counter.
	always_ff @(posedge clk) begin
		if (w_we) begin
			wmem[w_wa] <= w_wd;
		end
		w_rd_q <= wmem[j_q];
	end

	// Child memory: written once per new node, read at the walk position.
	always_ff @(posedge clk) begin
		if (state_q == ST_NODE) begin
			cmem[i_q] <= {sc_b, sc_a};
		end
		c_rd_q <= cmem[walk_q];
	end

	// Leaf symbol memory.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && cmd == hufd_pkg::CMD_LOAD && load_ok) begin
			smem[leaf_count_q[SA-1:0]] <= req.entry_symbol;
		end
		s_rd_q <= smem[leaf_q[SA-1:0]];
	end

	// Scan unit sees every free root in index order.
	assign scan_ctl.clear = (state_q == ST_SCAN) && (j_q == '0) && !vld_s1;
	assign scan_ctl.valid = (state_q == ST_SCAN) && vld_s1 && !w_rd_q[WW];

	hufd_scan #(
		.NW (NW)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (scan_ctl),
		.idx    (idx_s1),
		.weight (w_rd_q[WW-1:0]),
		.a      (sc_a),
		.wa     (sc_wa),
		.b      (sc_b),
		.wb     (sc_wb)
	);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			total_q <= cfg.data;
		end
	end

	// Sequencer: commands, tree build, bit walk and result output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			leaf_count_q <= '0;
			walk_q       <= '0;
			root_q       <= '0;
			leaf_q       <= '0;
			i_q          <= '0;
			j_q          <= '0;
			emitted_q    <= '0;
			tree_valid_q <= 1'b0;
			vld_s1       <= 1'b0;
			idx_s1       <= '0;
			bit_q        <= '0;
			held_q       <= 1'b0;
			o_valid_q    <= 1'b0;
		end else begin
			if (rsp.ready) begin
				o_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (cmd)
							hufd_pkg::CMD_CLEAR: begin
								leaf_count_q <= '0;
								walk_q       <= '0;
								emitted_q    <= '0;
								tree_valid_q <= 1'b0;
							end
							hufd_pkg::CMD_LOAD: begin
								if (load_ok) begin
									leaf_count_q <= leaf_count_q + 1'b1;
								end
								tree_valid_q <= 1'b0;
							end
							hufd_pkg::CMD_BUILD: begin
								i_q <= leaf_count_n;
								j_q <= '0;
								state_q <= (leaf_count_q == '0) ? ST_ACK : ST_CLR_RD;
							end
							hufd_pkg::CMD_DATA: begin
								byte_q <= req.data_byte;
								bit_q  <= '0;
								held_q <= 1'b0;
								if (tree_valid_q && leaf_count_q >= CW'(2)) begin
									state_q <= ST_STEP;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				// Clear the joined flags of the leaves.
				ST_CLR_RD: begin
					if ({1'b0, j_q} < (NW+1)'(leaf_count_q)) begin
						state_q <= ST_CLR_WR;
					end else begin
						j_q    <= '0;
						vld_s1 <= 1'b0;
						state_q <= ({1'b0, i_q} + 1'b1 < two_n) ? ST_SCAN : ST_ACK;
					end
				end
				ST_CLR_WR: begin
					j_q     <= j_q + 1'b1;
					state_q <= ST_CLR_RD;
				end
				// Stream nodes 0 .. i-1 through the scan unit.
				ST_SCAN: begin
					if (j_q < i_q) begin
						vld_s1 <= 1'b1;
						idx_s1 <= j_q;
						j_q    <= j_q + 1'b1;
					end else begin
						vld_s1 <= 1'b0;
						if (!vld_s1) begin
							state_q <= ST_NODE;
						end
					end
				end
				ST_NODE: begin
					state_q <= ST_JOIN_A;
				end
				ST_JOIN_A: begin
					state_q <= ST_JOIN_B;
				end
				ST_JOIN_B: begin
					i_q    <= i_q + 1'b1;
					j_q    <= '0;
					vld_s1 <= 1'b0;
					state_q <= ({1'b0, i_q} + 2'd2 < two_n) ? ST_SCAN : ST_ACK;
				end
				// Finish the build and acknowledge it.
				ST_ACK: begin
					if (out_free) begin
						tree_valid_q <= (leaf_count_q != '0);
						root_q       <= NW'(two_n - 2'd2);
						walk_q       <= (leaf_count_q != '0) ? NW'(two_n - 2'd2) : '0;
						emitted_q    <= '0;
						o_valid_q    <= 1'b1;
						o_kind_q     <= hufd_pkg::KIND_ACK;
						o_sym_q      <= '0;
						o_last_q     <= 1'b1;
						o_done_q     <= (total_q == '0);
						state_q      <= ST_IDLE;
					end
				end
				// One code bit: follow the child read for the current node.
				ST_STEP: begin
					if (bit_q == 4'd8 || emitted_q >= total_q) begin
						state_q <= ST_FLUSH;
					end else begin
						byte_q <= byte_q << 1;
						bit_q  <= bit_q + 1'b1;
						if (next_node < leaf_count_n) begin
							leaf_q  <= next_node;
							walk_q  <= root_q;
							state_q <= ST_WAIT_L;
						end else begin
							walk_q  <= next_node;
							state_q <= ST_WAIT_N;
						end
					end
				end
				ST_WAIT_N: begin
					state_q <= ST_STEP;
				end
				ST_WAIT_L: begin
					state_q <= ST_SYM;
				end
				// A leaf was reached: hand the older held symbol out first.
				ST_SYM: begin
					if (!held_q || out_free) begin
						if (held_q) begin
							o_valid_q <= 1'b1;
							o_kind_q  <= hufd_pkg::KIND_SYMBOL;
							o_sym_q   <= held_sym_q;
							o_last_q  <= 1'b0;
							o_done_q  <= held_done_q;
						end
						held_q      <= 1'b1;
						held_sym_q  <= s_rd_q;
						held_done_q <= (emitted_q + 1'b1 >= total_q);
						emitted_q   <= emitted_q + 1'b1;
						state_q     <= ST_STEP;
					end
				end
				// End of the byte: the held symbol is the last of the item.
				ST_FLUSH: begin
					if (!held_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						o_valid_q <= 1'b1;
						o_kind_q  <= hufd_pkg::KIND_SYMBOL;
						o_sym_q   <= held_sym_q;
						o_last_q  <= 1'b1;
						o_done_q  <= held_done_q;
						held_q    <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the static Huffman tree decoder. Directed tests cover empty,
// single-leaf and full tables, tie-heavy weights, the symbol total extremes
// and table invalidation; random streams then load leaves, build trees and
// decode random bytes. A local tree model predicts every result, and a
// checker compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int unsigned NODES       = 2 * hufd_pkg::MAX_SYMBOLS_DEF - 1;
	localparam int unsigned CYCLE_LIMIT = 3000000;
	localparam int unsigned SETTLE      = 100;

	typedef struct packed {
		logic                       kind;
		logic [hufd_pkg::SYM_W-1:0] symbol;
		logic                       last_of_item;
		logic                       stream_done;
	} decode_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	hufd_req_if req_ch ();
	hufd_rsp_if rsp_ch ();
	hufd_cfg_if cfg_ch ();

	huffman_tree_decoder_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Local copy of the decoder state.
	logic [hufd_pkg::WEIGHT_W-1:0] tree_weight [NODES];
	logic [8:0]                    tree_left [NODES];
	logic [8:0]                    tree_right [NODES];
	bit                            tree_joined [NODES];
	logic [hufd_pkg::SYM_W-1:0]    leaf_byte [hufd_pkg::MAX_SYMBOLS_DEF];
	int unsigned                   leaves;
	int unsigned                   cur_node;
	int unsigned                   symbols_out;
	logic [hufd_pkg::TOTAL_W-1:0]  total_symbols;
	bit                            tree_ok;

	decode_result_t pending_results [$];
	int unsigned    fail_count;
	int unsigned    cycle_count;
	bit             idle_on;
	int unsigned    hold_cycles;

	always #10 clk = ~clk;

	// Print one mismatch line and count it.
	task automatic report_mismatch(input string what, input int unsigned exp_v,
			input int unsigned got_v);
		$display("MISMATCH at cycle %0d: %s expected %0h got %0h", cycle_count, what,
			exp_v, got_v);
		fail_count++;
	endtask

	// Join the loaded leaves into a tree with the decoder's tie rules.
	function automatic void build_code_tree();
		int unsigned n;
		int unsigned i;
		int unsigned j;
		int unsigned first;
		int unsigned a;
		int unsigned b;
		n = leaves;
		for (i = 0; i < n; i++) tree_joined[i] = 1'b0;
		for (i = n; i + 1 < 2 * n; i++) begin
			first = 0;
			while (first < i && tree_joined[first]) first++;
			a = first;
			b = first;
			for (j = first; j < i; j++) begin
				if (!tree_joined[j]) begin
					if (tree_weight[j] < tree_weight[a]) a = j;
					if (tree_weight[j] >= tree_weight[b]) b = j;
				end
			end
			for (j = first; j < i; j++) begin
				if (!tree_joined[j] && j != a && tree_weight[j] < tree_weight[b]) b = j;
			end
			tree_weight[i] = tree_weight[a] + tree_weight[b];
			tree_left[i]   = a[8:0];
			tree_right[i]  = b[8:0];
			tree_joined[i] = 1'b0;
			tree_joined[a] = 1'b1;
			tree_joined[b] = 1'b1;
		end
		tree_ok     = (n >= 1);
		cur_node    = (n >= 1) ? 2 * n - 2 : 0;
		symbols_out = 0;
	endfunction

	// Work out the results of one accepted command and queue them.
	function automatic void predict_command(input hufd_pkg::cmd_t c,
			input logic [hufd_pkg::SYM_W-1:0] sym,
			input logic [hufd_pkg::EWEIGHT_W-1:0] wgt,
			input logic [hufd_pkg::BYTE_W-1:0] data);
		decode_result_t r;
		decode_result_t outs [$];
		int unsigned root;
		int bit_pos;
		case (c)
			hufd_pkg::CMD_CLEAR: begin
				leaves      = 0;
				cur_node    = 0;
				symbols_out = 0;
				tree_ok     = 1'b0;
			end
			hufd_pkg::CMD_LOAD: begin
				if (leaves < hufd_pkg::MAX_SYMBOLS_DEF) begin
					leaf_byte[leaves]   = sym;
					tree_weight[leaves] = {8'd0, wgt};
					tree_joined[leaves] = 1'b0;
					leaves++;
				end
				tree_ok = 1'b0;
			end
			hufd_pkg::CMD_BUILD: begin
				build_code_tree();
				r.kind         = hufd_pkg::KIND_ACK;
				r.symbol       = '0;
				r.last_of_item = 1'b0;
				r.stream_done  = (symbols_out >= total_symbols);
				outs.push_back(r);
			end
			default: begin
				if (tree_ok && leaves >= 2) begin
					root = 2 * leaves - 2;
					for (bit_pos = 7; bit_pos >= 0; bit_pos--) begin
						if (symbols_out >= total_symbols) break;
						cur_node = data[bit_pos] ? tree_right[cur_node] : tree_left[cur_node];
						if (cur_node < leaves) begin
							symbols_out++;
							r.kind         = hufd_pkg::KIND_SYMBOL;
							r.symbol       = leaf_byte[cur_node];
							r.last_of_item = 1'b0;
							r.stream_done  = (symbols_out >= total_symbols);
							outs.push_back(r);
							cur_node = root;
						end
					end
				end
			end
		endcase
		if (outs.size() > 0) outs[outs.size() - 1].last_of_item = 1'b1;
		foreach (outs[k]) pending_results.push_back(outs[k]);
	endfunction

	// Offer one command item and wait for its transfer.
	task automatic send_item(input hufd_pkg::cmd_t c,
			input logic [hufd_pkg::SYM_W-1:0] sym = '0,
			input logic [hufd_pkg::EWEIGHT_W-1:0] wgt = 24'd1,
			input logic [hufd_pkg::BYTE_W-1:0] data = '0);
		int unsigned gap;
		gap = idle_on ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid        = 1'b1;
		req_ch.cmd          = c;
		req_ch.entry_symbol = sym;
		req_ch.entry_weight = wgt;
		req_ch.data_byte    = data;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		predict_command(c, sym, wgt, data);
		@(negedge clk);
	endtask

	// Stop offering and wait until every predicted result has arrived.
	task automatic drain();
		req_ch.valid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Write the symbol total register; the decoder is idle here.
	task automatic write_total(input logic [hufd_pkg::TOTAL_W-1:0] value);
		drain();
		cfg_ch.valid = 1'b1;
		cfg_ch.data  = value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		total_symbols = value;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	function automatic logic [hufd_pkg::EWEIGHT_W-1:0] pick_weight(input bit tie_heavy);
		if (tie_heavy) return 24'($urandom_range(1, 4));
		return 24'($urandom_range(1, 24'hFFFFFF));
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// Load a table, build it and decode a run of random bytes.
	task automatic decode_stream(input int unsigned n_leaves, input int unsigned n_bytes,
			input bit tie_heavy);
		send_item(hufd_pkg::CMD_CLEAR);
		for (int unsigned k = 0; k < n_leaves; k++)
			send_item(hufd_pkg::CMD_LOAD, rand_byte(), pick_weight(tie_heavy));
		send_item(hufd_pkg::CMD_BUILD);
		for (int unsigned k = 0; k < n_bytes; k++)
			send_item(hufd_pkg::CMD_DATA, '0, 24'd1, rand_byte());
	endtask

	// Empty and single-leaf tables acknowledge builds and decode nothing.
	task automatic test_degenerate_tables();
		write_total(32'd0);
		send_item(hufd_pkg::CMD_BUILD);
		send_item(hufd_pkg::CMD_DATA, '0, 24'd1, 8'hA5);
		send_item(hufd_pkg::CMD_LOAD, 8'hFF, 24'hFFFFFF);
		send_item(hufd_pkg::CMD_BUILD);
		send_item(hufd_pkg::CMD_DATA, '0, 24'd1, 8'hFF);
		drain();
	endtask

	// Small trees with ties, the total extremes, clear and invalidation.
	task automatic test_small_trees();
		send_item(hufd_pkg::CMD_CLEAR);
		send_item(hufd_pkg::CMD_LOAD, 8'h00, 24'd1);
		send_item(hufd_pkg::CMD_LOAD, 8'h41, 24'd1);
		send_item(hufd_pkg::CMD_LOAD, 8'h42, 24'd2);
		send_item(hufd_pkg::CMD_LOAD, 8'hFF, 24'd2);
		send_item(hufd_pkg::CMD_BUILD);
		// A total of zero means the stream is already done.
		send_item(hufd_pkg::CMD_DATA, '0, 24'd1, 8'h00);
		write_total(32'hFFFFFFFF);
		send_item(hufd_pkg::CMD_BUILD);
		send_item(hufd_pkg::CMD_DATA, '0, 24'd1, 8'h00);
		send_item(hufd_pkg::CMD_DATA, '0, 24'd1, 8'hFF);
		send_item(hufd_pkg::CMD_DATA, '0, 24'd1, 8'h5A);
		// A load after the build leaves no valid tree.
		send_item(hufd_pkg::CMD_LOAD, 8'h7E, 24'hFFFFFF);
		send_item(hufd_pkg::CMD_DATA, '0, 24'd1, 8'h33);
		send_item(hufd_pkg::CMD_BUILD);
		send_item(hufd_pkg::CMD_DATA, '0, 24'd1, 8'hC3);
		send_item(hufd_pkg::CMD_CLEAR);
		send_item(hufd_pkg::CMD_DATA, '0, 24'd1, 8'hC3);
		// The stream ends in the middle of a byte.
		write_total(32'd3);
		decode_stream(3, 3, 1'b1);
		drain();
	endtask

	// A full table, where one more load is ignored.
	task automatic test_full_table();
		write_total(32'd200);
		send_item(hufd_pkg::CMD_CLEAR);
		for (int unsigned k = 0; k <= hufd_pkg::MAX_SYMBOLS_DEF; k++)
			send_item(hufd_pkg::CMD_LOAD, k[7:0], pick_weight(k[0]));
		send_item(hufd_pkg::CMD_BUILD);
		for (int unsigned k = 0; k < 12; k++)
			send_item(hufd_pkg::CMD_DATA, '0, 24'd1, rand_byte());
		drain();
	endtask

	// Random streams with occasional stray commands between them.
	task automatic test_random_streams();
		int unsigned sent;
		int unsigned n_leaves;
		int unsigned n_bytes;
		sent = 0;
		while (sent < 110) begin
			idle_on = ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 3))
				0: write_total(32'hFFFFFFFF);
				1: write_total($urandom);
				default: write_total($urandom_range(1, 60));
			endcase
			n_leaves = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64)
				: $urandom_range(2, 12);
			n_bytes = $urandom_range(8, 24);
			decode_stream(n_leaves, n_bytes, 1'($urandom_range(0, 1)));
			sent += n_leaves + n_bytes + 2;
			if ($urandom_range(0, 3) == 0) begin
				send_item(hufd_pkg::cmd_t'($urandom_range(0, 3)), rand_byte(),
					pick_weight(1'b0), rand_byte());
				send_item(hufd_pkg::CMD_DATA, '0, 24'd1, rand_byte());
				sent += 2;
			end
		end
		idle_on = 1'b1;
		drain();
	endtask

	// The receiver holds off while bytes keep coming, so the decoder stalls.
	task automatic test_backpressure();
		write_total(32'hFFFFFFFF);
		hold_cycles = 600;
		decode_stream(2, 40, 1'b0);
		drain();
	endtask

	// Result receiver: random stall before each transfer while idle_on is set, or a hold of hold_cycles.
	initial begin
		int unsigned wait_n;
		rsp_ch.ready = 1'b0;
		forever begin
			wait_n = idle_on ? $urandom_range(0, 16) : 0;
			if (hold_cycles > 0) begin
				wait_n = hold_cycles;
				hold_cycles = 0;
			end
			if (wait_n > 0) begin
				rsp_ch.ready = 1'b0;
				repeat (wait_n) @(negedge clk);
			end
			rsp_ch.ready = 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
			@(negedge clk);
		end
	end

	// Compare each result transfer with the oldest prediction.
	always @(posedge clk) begin
		decode_result_t exp_r;
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, symbol", 0, rsp_ch.symbol);
			end else begin
				exp_r = pending_results.pop_front();
				if (rsp_ch.kind !== exp_r.kind)
					report_mismatch("kind", exp_r.kind, rsp_ch.kind);
				if (rsp_ch.symbol !== exp_r.symbol)
					report_mismatch("symbol", exp_r.symbol, rsp_ch.symbol);
				if (rsp_ch.last_of_item !== exp_r.last_of_item)
					report_mismatch("last_of_item", exp_r.last_of_item, rsp_ch.last_of_item);
				if (rsp_ch.stream_done !== exp_r.stream_done)
					report_mismatch("stream_done", exp_r.stream_done, rsp_ch.stream_done);
			end
		end
	end

	// Test sequence.
	initial begin
		req_ch.valid        = 1'b0;
		req_ch.cmd          = hufd_pkg::CMD_CLEAR;
		req_ch.entry_symbol = '0;
		req_ch.entry_weight = '0;
		req_ch.data_byte    = '0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.data         = '0;
		leaves        = 0;
		cur_node      = 0;
		symbols_out   = 0;
		total_symbols = '0;
		tree_ok       = 1'b0;
		fail_count    = 0;
		cycle_count   = 0;
		idle_on       = 1'b1;
		hold_cycles   = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_degenerate_tables();
		test_small_trees();
		test_full_table();
		test_random_streams();
		test_backpressure();
		if (pending_results.size() != 0)
			report_mismatch("results never arrived", pending_results.size(), 0);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

[sim.f]
design/hufd_pkg.sv
design/hufd_req_if.sv
design/hufd_rsp_if.sv
design/hufd_cfg_if.sv
design/hufd_scan.sv
design/huffman_tree_decoder_unit.sv
verif/tb_top.sv
